// File: rtl/core/ctb_pkg.sv
// ctb_pkg: shared types and constants for the countdown timer bank
// command codes, field widths, controller states, control/status structs
// no dependencies
package ctb_pkg;

   localparam int FUNC_W    = 3;
   localparam int ID_W      = 8;
   localparam int MS_W      = 20;
   localparam int CNT_OUT_W = 5;

   localparam logic [MS_W-1:0] DFLT_SHORT_MS = 20'd3000;
   localparam logic [MS_W-1:0] DFLT_MID_MS   = 20'd5000;
   localparam logic [MS_W-1:0] DFLT_LONG_MS  = 20'd30000;

   typedef enum logic [FUNC_W-1:0] {
      FN_START      = 3'd0,
      FN_START_DFLT = 3'd1,
      FN_STOP       = 3'd2,
      FN_STOP_ALL   = 3'd3,
      FN_TICK       = 3'd4,
      FN_QUERY      = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_REPORT
   } ctl_state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic scan_step;
      logic walk_init;
      logic walk_adv;
      logic emit_exp;
   } ctb_cmd_type;

   typedef struct packed {
      logic out_free;
      logic scan_done;
      logic hit_any;
      logic walk_hit;
      logic walk_last;
   } ctb_stat_type;

   // default load per slot: two slots mid, two long, rest short
   function automatic logic [MS_W-1:0] dflt_ms(input logic [ID_W-1:0] id);
      logic [MS_W-1:0] ms;
      unique case (id)
         8'd2, 8'd9:  ms = DFLT_MID_MS;
         8'd5, 8'd10: ms = DFLT_LONG_MS;
         default:     ms = DFLT_SHORT_MS;
      endcase
      return ms;
   endfunction

endpackage

// File: rtl/core/ctb_if.sv
// ctb_if: request and response channel interfaces of the timer bank
// valid/ready handshake plus payload; depends on ctb_pkg
interface ctb_req_if import ctb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ID_W-1:0]   timer_id;
   logic [MS_W-1:0]   duration_ms;
   logic [MS_W-1:0]   delta_ms;

   modport source (output valid, func, timer_id, duration_ms, delta_ms, input ready);
   modport sink   (input valid, func, timer_id, duration_ms, delta_ms, output ready);
endinterface

interface ctb_rsp_if import ctb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ID_W-1:0]      result_id;
   logic                 expired;
   logic                 first_start;
   logic                 invalid_id;
   logic                 is_running;
   logic [MS_W-1:0]      remaining_ms;
   logic [CNT_OUT_W-1:0] active_count;
   logic                 last;

   modport source (output valid, result_id, expired, first_start, invalid_id, is_running,
                   remaining_ms, active_count, last, input ready);
   modport sink   (input valid, result_id, expired, first_start, invalid_id, is_running,
                   remaining_ms, active_count, last, output ready);
endinterface

// File: rtl/core/ctb_ctl.sv
// ctb_ctl: sequencing state machine of the timer bank
// drives ctb_dp through ctb_cmd_type, reads ctb_stat_type; depends on ctb_pkg
module ctb_ctl import ctb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   output logic              req_ready,
   input  ctb_stat_type      stat,
   output ctb_cmd_type       cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = (req_func == FN_TICK) ? ST_SCAN : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               // no expiry: the single tick response goes out through exec
               if (stat.hit_any) begin
                  cmd.walk_init = 1'b1;
                  state_in      = ST_REPORT;
               end else begin
                  state_in = ST_EXEC;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_REPORT: begin
            if (stat.walk_hit) begin
               if (stat.out_free) begin
                  cmd.emit_exp = 1'b1;
                  if (stat.walk_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               cmd.walk_adv = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: rtl/core/ctb_dp.sv
// ctb_dp: timer bank datapath - time store, run/started flags, counters,
// tick scan pipeline, expiry walk and response register; depends on ctb_pkg
module ctb_dp import ctb_pkg::*; #(
   parameter int NUM_TIMERS = 19
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctb_cmd_type          cmd,
   output ctb_stat_type         stat,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [ID_W-1:0]      req_timer_id,
   input  logic [MS_W-1:0]      req_duration_ms,
   input  logic [MS_W-1:0]      req_delta_ms,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [ID_W-1:0]      rsp_result_id,
   output logic                 rsp_expired,
   output logic                 rsp_first_start,
   output logic                 rsp_invalid_id,
   output logic                 rsp_is_running,
   output logic [MS_W-1:0]      rsp_remaining_ms,
   output logic [CNT_OUT_W-1:0] rsp_active_count,
   output logic                 rsp_last
);

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = $clog2(NUM_TIMERS + 1);
   localparam logic [CW-1:0]   CNT_MAX  = CW'(NUM_TIMERS);
   localparam logic [ID_W-1:0] ID_LIMIT = ID_W'(NUM_TIMERS);

   // latched request
   logic [FUNC_W-1:0] func_ff;
   logic [ID_W-1:0]   id_ff;
   logic [MS_W-1:0]   dur_ff;
   logic [MS_W-1:0]   delta_ff;

   logic [NUM_TIMERS-1:0] run_ff, run_in;
   logic [NUM_TIMERS-1:0] ever_ff, ever_in;
   logic [NUM_TIMERS-1:0] hit_ff, hit_in, hit_rest;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  pipe_ff, pipe_in;
   logic [IW-1:0]         pidx_ff;

   logic [MS_W-1:0] time_mem [NUM_TIMERS];
   logic [MS_W-1:0] rd_data_ff;
   logic            rd_en;
   logic [IW-1:0]   rd_addr;
   logic            wr_en;
   logic [IW-1:0]   wr_addr;
   logic [MS_W-1:0] wr_data;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0] rsp_id_ff;
   logic            rsp_exp_ff, rsp_first_ff, rsp_inv_ff, rsp_run_ff, rsp_last_ff;
   logic [MS_W-1:0] rsp_rem_ff;
   logic [CNT_OUT_W-1:0] rsp_count_ff;

   func_type        func_e;
   logic            id_ok;
   logic [IW-1:0]   ix;
   logic [IW-1:0]   walk_ix;
   logic            scan_issue;
   logic            proc, proc_exp;
   logic            out_free;
   logic            load_out;
   logic [ID_W-1:0] o_id;
   logic            o_exp, o_first, o_inv, o_run, o_last;
   logic [MS_W-1:0] o_rem;
   logic [MS_W-1:0] start_ms;

   assign func_e     = func_type'(func_ff);
   assign id_ok      = id_ff < ID_LIMIT;
   assign ix         = id_ff[IW-1:0];
   assign walk_ix    = idx_ff[IW-1:0];
   assign scan_issue = cmd.scan_step && (idx_ff != CNT_MAX);
   assign proc       = pipe_ff && run_ff[pidx_ff];
   assign proc_exp   = proc && (rd_data_ff <= delta_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rd_en      = cmd.load_req || scan_issue;
   assign rd_addr    = cmd.load_req ? req_timer_id[IW-1:0] : idx_ff[IW-1:0];
   assign start_ms   = (func_e == FN_START) ? dur_ff : dflt_ms(id_ff);

   always_comb begin
      hit_rest          = hit_ff;
      hit_rest[walk_ix] = 1'b0;
   end

   assign stat.out_free  = out_free;
   assign stat.scan_done = (idx_ff == CNT_MAX) && !pipe_ff;
   assign stat.hit_any   = |hit_ff;
   assign stat.walk_hit  = hit_ff[walk_ix];
   assign stat.walk_last = (hit_rest == '0);

   always_comb begin
      run_in   = run_ff;
      ever_in  = ever_ff;
      hit_in   = hit_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = ix;
      wr_data  = start_ms;
      load_out = 1'b0;
      o_id     = id_ff;
      o_exp    = 1'b0;
      o_first  = 1'b0;
      o_inv    = 1'b0;
      o_run    = 1'b0;
      o_rem    = '0;
      o_last   = 1'b1;

      if (cmd.load_req) begin
         hit_in = '0;
      end

      if (cmd.exec) begin
         load_out = 1'b1;
         unique case (func_e)
            FN_START, FN_START_DFLT: begin
               if (!id_ok) begin
                  o_inv = 1'b1;
               end else begin
                  o_first     = !ever_ff[ix];
                  ever_in[ix] = 1'b1;
                  run_in[ix]  = 1'b1;
                  if (!run_ff[ix]) begin
                     count_in = count_ff + 1'b1;
                  end
                  wr_en = 1'b1;
                  o_run = 1'b1;
                  o_rem = start_ms;
               end
            end
            FN_STOP: begin
               if (!id_ok) begin
                  o_inv = 1'b1;
               end else begin
                  run_in[ix] = 1'b0;
                  if (run_ff[ix]) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            FN_STOP_ALL: begin
               run_in   = '0;
               count_in = '0;
               o_id     = '0;
            end
            FN_TICK: begin
               o_id = '0;
            end
            FN_QUERY: begin
               if (!id_ok) begin
                  o_inv = 1'b1;
               end else begin
                  o_run = run_ff[ix];
                  o_rem = run_ff[ix] ? rd_data_ff : '0;
               end
            end
            default: ;
         endcase
      end

      // tick scan: data for slot pidx_ff arrived from the store last cycle
      if (proc) begin
         if (proc_exp) begin
            run_in[pidx_ff] = 1'b0;
            hit_in[pidx_ff] = 1'b1;
            count_in        = count_ff - 1'b1;
         end else begin
            wr_en   = 1'b1;
            wr_addr = pidx_ff;
            wr_data = rd_data_ff - delta_ff;
         end
      end

      if (cmd.emit_exp) begin
         load_out = 1'b1;
         o_id     = ID_W'(idx_ff);
         o_exp    = 1'b1;
         o_last   = (hit_rest == '0);
         hit_in   = hit_rest;
      end
   end

   always_comb begin
      idx_in  = idx_ff;
      pipe_in = scan_issue;
      if (cmd.load_req || cmd.walk_init) begin
         idx_in = '0;
      end else if (scan_issue || cmd.walk_adv || cmd.emit_exp) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= '0;
         ever_ff      <= '0;
         hit_ff       <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         pipe_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         ever_ff      <= ever_in;
         hit_ff       <= hit_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         pipe_ff      <= pipe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff  <= req_func;
         id_ff    <= req_timer_id;
         dur_ff   <= req_duration_ms;
         delta_ff <= req_delta_ms;
      end
      if (scan_issue) begin
         pidx_ff <= idx_ff[IW-1:0];
      end
      if (load_out) begin
         rsp_id_ff    <= o_id;
         rsp_exp_ff   <= o_exp;
         rsp_first_ff <= o_first;
         rsp_inv_ff   <= o_inv;
         rsp_run_ff   <= o_run;
         rsp_rem_ff   <= o_rem;
         rsp_count_ff <= CNT_OUT_W'(count_in);
         rsp_last_ff  <= o_last;
      end
   end

   // remaining-time store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= time_mem[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_id    = rsp_id_ff;
   assign rsp_expired      = rsp_exp_ff;
   assign rsp_first_start  = rsp_first_ff;
   assign rsp_invalid_id   = rsp_inv_ff;
   assign rsp_is_running   = rsp_run_ff;
   assign rsp_remaining_ms = rsp_rem_ff;
   assign rsp_active_count = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

   a_count_tracks_run: assert property (@(posedge clock) disable iff (reset)
      $countones(run_ff) == int'(count_ff))
      else $error("active counter out of step with run flags");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> out_free)
      else $error("response register loaded while still held");

   a_hit_is_stopped: assert property (@(posedge clock) disable iff (reset)
      (hit_ff & run_ff) == '0)
      else $error("expired slot still marked running");

   a_scan_slot_range: assert property (@(posedge clock) disable iff (reset)
      pipe_ff |-> (int'(pidx_ff) < NUM_TIMERS))
      else $error("scan processed a slot beyond the bank");

endmodule

// File: rtl/core/countdown_timer_bank.sv
// countdown_timer_bank: a bank of NUM_TIMERS countdown timers.
// Requests arrive on req_ch (func, timer_id, duration_ms, delta_ms) and
// responses leave on rsp_ch; both are valid/ready, a request moves when
// both are high at a rising clock edge. One request is handled at a time.
// Start, stop, stop-all and query give one registered response, loaded from
// the EXEC state once the response register is free; the bank then returns
// to IDLE, so the next request is not taken before that response is loaded.
// A tick walks every slot through the time store one slot a cycle; with no
// expiry its single response is then loaded through EXEC. Otherwise it walks
// the expiry flags one slot a cycle, holding on an expired slot while the
// response register is not yet free, to report each expired timer in
// ascending order. Either way the next request can be taken in the cycle
// after the final response is loaded. The store's single read port makes
// the tick scan slot-serial.
// Every response carries last; on a tick with expiries it is set on the highest.
// Reset (synchronous, active high) stops every timer and clears the started
// and running flags; the time store is not cleared, a stored time is read only
// while its slot is running. If rsp_ch.ready is held low the response stays in
// its register; one more request can be taken, then waits with req_ch.ready low.
// Depends on ctb_pkg, ctb_if, ctb_ctl and ctb_dp.
module countdown_timer_bank import ctb_pkg::*; #(
   parameter int NUM_TIMERS = 19
) (
   input logic        clock,
   input logic        reset,
   ctb_req_if.sink    req_ch,
   ctb_rsp_if.source  rsp_ch
);

   ctb_cmd_type  cmd;
   ctb_stat_type stat;
   logic         req_ready;

   ctb_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ctb_dp #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_ch.func),
      .req_timer_id     (req_ch.timer_id),
      .req_duration_ms  (req_ch.duration_ms),
      .req_delta_ms     (req_ch.delta_ms),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_result_id    (rsp_ch.result_id),
      .rsp_expired      (rsp_ch.expired),
      .rsp_first_start  (rsp_ch.first_start),
      .rsp_invalid_id   (rsp_ch.invalid_id),
      .rsp_is_running   (rsp_ch.is_running),
      .rsp_remaining_ms (rsp_ch.remaining_ms),
      .rsp_active_count (rsp_ch.active_count),
      .rsp_last         (rsp_ch.last)
   );

   assign req_ch.ready = req_ready;

endmodule

// File: dv/countdown_timer_bank_tb.sv
`timescale 1ns / 100ps
// countdown_timer_bank_tb: self-checking bench for the countdown timer bank
// predicts every response from its own copy of the timer state and compares
// depends on ctb_pkg, ctb_if and the countdown_timer_bank rtl
module countdown_timer_bank_tb;
   import ctb_pkg::*;

   localparam int NUM_TIMERS  = 19;
   localparam int CLK_HALF    = 4;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 50;
   localparam int SETTLE_CYCLES = 2 * NUM_TIMERS + 20;

   // spare command codes, outside the package enum
   localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
   localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   timer_id;
      logic [MS_W-1:0]   duration_ms;
      logic [MS_W-1:0]   delta_ms;
   } timer_req_type;

   typedef struct {
      logic [ID_W-1:0]      result_id;
      logic                 expired;
      logic                 first_start;
      logic                 invalid_id;
      logic                 is_running;
      logic [MS_W-1:0]      remaining_ms;
      logic [CNT_OUT_W-1:0] active_count;
      logic                 last;
   } timer_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ctb_req_if req_ch ();
   ctb_rsp_if rsp_ch ();

   countdown_timer_bank #(.NUM_TIMERS(NUM_TIMERS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #CLK_HALF clock = ~clock;

   timer_req_type pending_req_q[$];
   timer_rsp_type expected_rsp_q[$];
   timer_req_type offered_req;

   // predicted timer bank contents
   logic [MS_W-1:0] slot_ms   [NUM_TIMERS];
   logic            slot_run  [NUM_TIMERS];
   logic            slot_used [NUM_TIMERS];

   int  gap_pct = 0;
   int  stall_pct = 0;
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  hold_arm = 1'b0;
   logic rsp_hold = 1'b0;

   function automatic logic [MS_W-1:0] default_load(input logic [ID_W-1:0] id);
      if (id == 2 || id == 9)
         return DFLT_MID_MS;
      if (id == 5 || id == 10)
         return DFLT_LONG_MS;
      return DFLT_SHORT_MS;
   endfunction

   function automatic logic [CNT_OUT_W-1:0] running_count();
      logic [CNT_OUT_W-1:0] n;
      n = '0;
      for (int i = 0; i < NUM_TIMERS; i++)
         if (slot_run[i])
            n++;
      return n;
   endfunction

   // work out the responses of one accepted request and update the bank copy
   function automatic void predict_timer_rsp(input timer_req_type rq);
      timer_rsp_type r;
      logic       id_ok;
      int         slot;
      int         hits[$];
      logic [CNT_OUT_W-1:0] act;
      id_ok = rq.timer_id < NUM_TIMERS;
      slot = id_ok ? int'(rq.timer_id) : 0;
      r = '{result_id: rq.timer_id, expired: 1'b0, first_start: 1'b0, invalid_id: 1'b0,
            is_running: 1'b0, remaining_ms: '0, active_count: '0, last: 1'b1};
      unique case (rq.func)
         FN_START, FN_START_DFLT, FN_STOP, FN_QUERY: begin
            if (!id_ok) begin
               r.invalid_id = 1'b1;
            end else if (rq.func == FN_STOP) begin
               slot_run[slot] = 1'b0;
            end else if (rq.func == FN_QUERY) begin
               r.is_running = slot_run[slot];
               r.remaining_ms = slot_run[slot] ? slot_ms[slot] : '0;
            end else begin
               slot_ms[slot] = (rq.func == FN_START_DFLT) ? default_load(rq.timer_id)
                                                          : rq.duration_ms;
               r.first_start = !slot_used[slot];
               slot_used[slot] = 1'b1;
               slot_run[slot] = 1'b1;
               r.is_running = 1'b1;
               r.remaining_ms = slot_ms[slot];
            end
            r.active_count = running_count();
            expected_rsp_q.push_back(r);
         end
         FN_STOP_ALL: begin
            for (int i = 0; i < NUM_TIMERS; i++)
               slot_run[i] = 1'b0;
            r.result_id = '0;
            expected_rsp_q.push_back(r);
         end
         FN_TICK: begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
               if (slot_run[i]) begin
                  if (slot_ms[i] <= rq.delta_ms) begin
                     slot_run[i] = 1'b0;
                     slot_ms[i] = '0;
                     hits.push_back(i);
                  end else begin
                     slot_ms[i] = slot_ms[i] - rq.delta_ms;
                  end
               end
            end
            act = running_count();
            r.active_count = act;
            if (hits.size() == 0) begin
               r.result_id = '0;
               expected_rsp_q.push_back(r);
            end else begin
               foreach (hits[k]) begin
                  r.result_id = ID_W'(hits[k]);
                  r.expired = 1'b1;
                  r.last = (k == hits.size() - 1);
                  expected_rsp_q.push_back(r);
               end
            end
         end
         default: begin
            r.active_count = running_count();
            expected_rsp_q.push_back(r);
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic timer_req_type random_request();
      timer_req_type rq;
      int pick;
      pick = $urandom_range(99);
      if (pick < 26)
         rq.func = FN_START;
      else if (pick < 36)
         rq.func = FN_START_DFLT;
      else if (pick < 46)
         rq.func = FN_STOP;
      else if (pick < 49)
         rq.func = FN_STOP_ALL;
      else if (pick < 75)
         rq.func = FN_TICK;
      else if (pick < 97)
         rq.func = FN_QUERY;
      else
         rq.func = $urandom_range(1) ? FN_SPARE_A : FN_SPARE_B;
      // mostly live slots, now and then any id at all
      rq.timer_id = ($urandom_range(99) < 88) ? ID_W'($urandom_range(NUM_TIMERS - 1))
                                              : ID_W'($urandom_range(255));
      rq.duration_ms = ($urandom_range(99) < 80) ? MS_W'($urandom_range(200))
                                                 : MS_W'($urandom_range(20'hFFFFF));
      rq.delta_ms = ($urandom_range(99) < 85) ? MS_W'($urandom_range(40))
                                              : MS_W'($urandom_range(20'hFFFFF));
      return rq;
   endfunction

   task automatic queue_req(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id,
                            input logic [MS_W-1:0] dur, input logic [MS_W-1:0] delta);
      timer_req_type rq;
      rq = '{func: func, timer_id: id, duration_ms: dur, delta_ms: delta};
      pending_req_q.push_back(rq);
   endtask

   task automatic drain();
      while (pending_req_q.size() != 0 || req_ch.valid || expected_rsp_q.size() != 0)
         @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            predict_timer_rsp(offered_req);
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_req_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
               offered_req = pending_req_q.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.func        <= offered_req.func;
               req_ch.timer_id    <= offered_req.timer_id;
               req_ch.duration_ms <= offered_req.duration_ms;
               req_ch.delta_ms    <= offered_req.delta_ms;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      timer_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response with no request outstanding, result_id %0d",
                      rsp_ch.result_id);
               mismatch_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("result_id", 32'(want.result_id), 32'(rsp_ch.result_id));
               check_field("expired", 32'(want.expired), 32'(rsp_ch.expired));
               check_field("first_start", 32'(want.first_start), 32'(rsp_ch.first_start));
               check_field("invalid_id", 32'(want.invalid_id), 32'(rsp_ch.invalid_id));
               check_field("is_running", 32'(want.is_running), 32'(rsp_ch.is_running));
               check_field("remaining_ms", 32'(want.remaining_ms),
                           32'(rsp_ch.remaining_ms));
               check_field("active_count", 32'(want.active_count),
                           32'(rsp_ch.active_count));
               check_field("last", 32'(want.last), 32'(rsp_ch.last));
            end
         end
         rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   // long receiver hold-off so the bank backs up onto its request port
   initial begin : rsp_hold_off
      wait (hold_arm);
      @(negedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rsp_hold = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         slot_ms[i] = '0;
         slot_run[i] = 1'b0;
         slot_used[i] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: idle and out-of-range queries, empty tick
      queue_req(FN_QUERY, 8'd0, 20'd0, 20'd0);
      queue_req(FN_QUERY, 8'd19, 20'd0, 20'd0);
      queue_req(FN_QUERY, 8'd255, 20'hFFFFF, 20'hFFFFF);
      queue_req(FN_TICK, 8'd0, 20'd0, 20'd0);
      // zero duration, restart of a used slot, widest duration
      queue_req(FN_START, 8'd1, 20'd0, 20'd0);
      queue_req(FN_START, 8'd0, 20'd5, 20'd0);
      queue_req(FN_START, 8'd0, 20'd5, 20'd0);
      queue_req(FN_START, 8'd18, 20'hFFFFF, 20'd0);
      // default loads, each distinct table value
      queue_req(FN_START_DFLT, 8'd2, 20'd0, 20'd0);
      queue_req(FN_START_DFLT, 8'd5, 20'd0, 20'd0);
      queue_req(FN_START_DFLT, 8'd9, 20'd0, 20'd0);
      queue_req(FN_START_DFLT, 8'd10, 20'd0, 20'd0);
      queue_req(FN_START_DFLT, 8'd3, 20'hFFFFF, 20'd0);
      queue_req(FN_START, 8'd19, 20'd7, 20'd0);
      queue_req(FN_START_DFLT, 8'd255, 20'd0, 20'd0);
      queue_req(FN_QUERY, 8'd18, 20'd0, 20'd0);
      // zero-length timer goes on a zero tick, then an exact-match expiry
      queue_req(FN_TICK, 8'd0, 20'd0, 20'd0);
      queue_req(FN_TICK, 8'd77, 20'd0, 20'd5);
      queue_req(FN_STOP, 8'd3, 20'd0, 20'd0);
      queue_req(FN_STOP, 8'd255, 20'd0, 20'd0);
      queue_req(FN_QUERY, 8'd3, 20'd0, 20'd0);
      // full-scale tick expires every running slot in order
      queue_req(FN_TICK, 8'd0, 20'd0, 20'hFFFFF);
      queue_req(FN_START, 8'd7, 20'd100, 20'd0);
      queue_req(FN_STOP_ALL, 8'd200, 20'd0, 20'd0);
      queue_req(FN_SPARE_A, 8'd255, 20'hFFFFF, 20'hFFFFF);
      queue_req(FN_SPARE_B, 8'd0, 20'd0, 20'd0);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         unique case (ph)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 76; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 76; end
            default: begin gap_pct = 7; stall_pct = 7; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++)
            pending_req_q.push_back(random_request());
         drain();
      end

      // back-pressure: sender keeps offering while the receiver holds off
      gap_pct = 0;
      stall_pct = 0;
      hold_arm = 1'b1;
      for (int n = 0; n < 20; n++)
         pending_req_q.push_back(random_request());
      drain();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: countdown_timer_bank.f
rtl/core/ctb_pkg.sv
rtl/core/ctb_if.sv
rtl/core/ctb_ctl.sv
rtl/core/ctb_dp.sv
rtl/core/countdown_timer_bank.sv
dv/countdown_timer_bank_tb.sv
